[rtl/battery_rc_model_step_unit_assert.svh]
// Assertion macros used by the checker file of the battery RC model step unit.
`ifndef BATTERY_RC_MODEL_STEP_UNIT_ASSERT_SVH
`define BATTERY_RC_MODEL_STEP_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent (may carry a ## delay).
`define BRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("battery RC model step unit: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("battery RC model step unit: assertion failed");

`endif

[rtl/brc_pkg.sv]
// Package of the battery RC model step unit: widths, codes, types and reset values.
package brc_pkg;

	localparam int CUR_W      = 24;
	localparam int VOLT_W     = 24;
	localparam int SOC_W      = 31;
	localparam int VRC_W      = 32;
	localparam int COEF_W     = 24;
	localparam int DECAY_W    = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int VACC_W     = 28;
	localparam int SACC_W     = 34;
	localparam int RACC_W     = 35;

	localparam logic [SOC_W-1:0] SOC_ONE = 31'd1073741824;

	localparam logic signed [COEF_W-1:0] RST_OCV_OFFSET    = 24'sd196608;
	localparam logic signed [COEF_W-1:0] RST_OCV_LINEAR    = 24'sd78643;
	localparam logic signed [COEF_W-1:0] RST_OCV_QUADRATIC = -24'sd6554;
	localparam logic [COEF_W-1:0]        RST_OHMIC_RES     = 24'd251658;
	localparam logic [DECAY_W-1:0]       RST_RC_DECAY      = 25'd16092521;
	localparam logic [COEF_W-1:0]        RST_RC_GAIN       = 24'd6847;
	localparam logic [COEF_W-1:0]        RST_SOC_STEP      = 24'd129679;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OCV_OFFSET    = 3'd0,
		REG_OCV_LINEAR    = 3'd1,
		REG_OCV_QUADRATIC = 3'd2,
		REG_OHMIC_RES     = 3'd3,
		REG_RC_DECAY      = 3'd4,
		REG_RC_GAIN       = 3'd5,
		REG_SOC_STEP      = 3'd6
	} reg_idx_t;

	// Products issued to the shared multiplier, in issue order.
	typedef enum logic [2:0] {
		OP_SS   = 3'd0,
		OP_C1S  = 3'd1,
		OP_C2SQ = 3'd2,
		OP_IR0  = 3'd3,
		OP_IK   = 3'd4,
		OP_AV   = 3'd5,
		OP_GI   = 3'd6
	} op_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ocv_offset;
		logic signed [COEF_W-1:0] ocv_linear;
		logic signed [COEF_W-1:0] ocv_quadratic;
		logic [COEF_W-1:0]        ohmic_resistance;
		logic [DECAY_W-1:0]       rc_decay;
		logic [COEF_W-1:0]        rc_gain;
		logic [COEF_W-1:0]        soc_step_per_amp;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic issue;
		op_t  op;
		logic commit;
	} cmd_t;

endpackage

[rtl/brc_if.sv]
// Stream interfaces of the battery RC model step unit: step input and result output.
interface brc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [brc_pkg::CUR_W-1:0]      cell_current;

	modport source (output valid, output cell_current, input ready);
	modport sink (input valid, input cell_current, output ready);
endinterface

interface brc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [brc_pkg::VOLT_W-1:0]     terminal_voltage;
	logic [brc_pkg::SOC_W-1:0]             state_of_charge;

	modport source (output valid, output terminal_voltage, output state_of_charge, input ready);
	modport sink (input valid, input terminal_voltage, input state_of_charge, output ready);
endinterface

[rtl/brc_cfg_regs.sv]
// Configuration register file of the battery RC model step unit.
module brc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [brc_pkg::CFG_IDX_W-1:0]     index,
	input  logic [brc_pkg::CFG_DATA_W-1:0]    data,
	output brc_pkg::cfg_t                     cfg
);

	brc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ocv_offset       <= brc_pkg::RST_OCV_OFFSET;
			cfg_q.ocv_linear       <= brc_pkg::RST_OCV_LINEAR;
			cfg_q.ocv_quadratic    <= brc_pkg::RST_OCV_QUADRATIC;
			cfg_q.ohmic_resistance <= brc_pkg::RST_OHMIC_RES;
			cfg_q.rc_decay         <= brc_pkg::RST_RC_DECAY;
			cfg_q.rc_gain          <= brc_pkg::RST_RC_GAIN;
			cfg_q.soc_step_per_amp <= brc_pkg::RST_SOC_STEP;
		end else if (wr_en) begin
			unique case (index)
				brc_pkg::REG_OCV_OFFSET:    cfg_q.ocv_offset       <= data[brc_pkg::COEF_W-1:0];
				brc_pkg::REG_OCV_LINEAR:    cfg_q.ocv_linear       <= data[brc_pkg::COEF_W-1:0];
				brc_pkg::REG_OCV_QUADRATIC: cfg_q.ocv_quadratic    <= data[brc_pkg::COEF_W-1:0];
				brc_pkg::REG_OHMIC_RES:     cfg_q.ohmic_resistance <= data[brc_pkg::COEF_W-1:0];
				brc_pkg::REG_RC_DECAY:      cfg_q.rc_decay         <= data[brc_pkg::DECAY_W-1:0];
				brc_pkg::REG_RC_GAIN:       cfg_q.rc_gain          <= data[brc_pkg::COEF_W-1:0];
				brc_pkg::REG_SOC_STEP:      cfg_q.soc_step_per_amp <= data[brc_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/brc_ctrl.sv]
// Controller of the battery RC model step unit: sequences the shared multiplier.
module brc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output brc_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t         state_q;
	brc_pkg::op_t   op_q;
	logic           out_valid_q;
	logic           load;
	logic           commit;

	assign in_ready = (state_q == ST_IDLE);
	assign load     = in_valid && in_ready;
	// A finished result moves to the output register once that register is free.
	assign commit   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load   = load;
		cmd.issue  = (state_q == ST_ISSUE);
		cmd.op     = op_q;
		cmd.commit = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= brc_pkg::OP_SS;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_ISSUE;
						op_q    <= brc_pkg::OP_SS;
					end
				end
				ST_ISSUE: begin
					if (op_q == brc_pkg::OP_GI) begin
						state_q <= ST_DRAIN;
					end else begin
						op_q <= brc_pkg::op_t'(op_q + 3'd1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/brc_datapath.sv]
// Datapath of the battery RC model step unit: shared multiplier, accumulators and state.
module brc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brc_pkg::cfg_t                       cfg,
	input  brc_pkg::cmd_t                       cmd,
	input  logic signed [brc_pkg::CUR_W-1:0]    cell_current,
	output logic signed [brc_pkg::VOLT_W-1:0]   terminal_voltage,
	output logic [brc_pkg::SOC_W-1:0]           state_of_charge
);

	logic signed [brc_pkg::CUR_W-1:0]   cur_q;
	logic [brc_pkg::SOC_W-1:0]          soc_q;
	logic signed [brc_pkg::VRC_W-1:0]   vrc_q;
	logic [brc_pkg::SOC_W-1:0]          sq_q;
	logic signed [brc_pkg::VACC_W-1:0]  volt_acc_q;
	logic signed [brc_pkg::SACC_W-1:0]  soc_next_q;
	logic signed [brc_pkg::RACC_W-1:0]  vrc_next_q;
	logic signed [brc_pkg::PROD_W-1:0]  prod_s1;
	brc_pkg::op_t                       op_s1;
	logic                               vld_s1;
	logic signed [brc_pkg::VOLT_W-1:0]  volt_out_q;
	logic [brc_pkg::SOC_W-1:0]          soc_out_q;

	logic signed [brc_pkg::MUL_W-1:0]   mul_a;
	logic signed [brc_pkg::MUL_W-1:0]   mul_b;
	logic signed [brc_pkg::PROD_W-1:0]  prod;
	logic signed [brc_pkg::MUL_W-1:0]   cur_ext;
	logic signed [brc_pkg::MUL_W-1:0]   soc_ext;
	logic signed [brc_pkg::PROD_W-1:0]  sh30;
	logic signed [brc_pkg::PROD_W-1:0]  sh24;
	logic signed [brc_pkg::PROD_W-1:0]  sh16;
	logic signed [brc_pkg::VRC_W-1:0]   vrc_sh8;
	logic signed [brc_pkg::VACC_W-1:0]  volt_init;
	logic signed [brc_pkg::VOLT_W-1:0]  volt_sat;
	logic [brc_pkg::SOC_W-1:0]          soc_clamped;
	logic signed [brc_pkg::VRC_W-1:0]   vrc_sat;

	assign cur_ext = {{(brc_pkg::MUL_W - brc_pkg::CUR_W){cur_q[brc_pkg::CUR_W-1]}}, cur_q};
	assign soc_ext = {{(brc_pkg::MUL_W - brc_pkg::SOC_W){1'b0}}, soc_q};

	always_comb begin
		unique case (cmd.op)
			brc_pkg::OP_SS: begin
				mul_a = soc_ext;
				mul_b = soc_ext;
			end
			brc_pkg::OP_C1S: begin
				mul_a = {{(brc_pkg::MUL_W - brc_pkg::COEF_W){cfg.ocv_linear[brc_pkg::COEF_W-1]}},
					cfg.ocv_linear};
				mul_b = soc_ext;
			end
			brc_pkg::OP_C2SQ: begin
				mul_a = {{(brc_pkg::MUL_W - brc_pkg::COEF_W){cfg.ocv_quadratic[brc_pkg::COEF_W-1]}},
					cfg.ocv_quadratic};
				mul_b = {{(brc_pkg::MUL_W - brc_pkg::SOC_W){1'b0}}, sq_q};
			end
			brc_pkg::OP_IR0: begin
				mul_a = cur_ext;
				mul_b = {{(brc_pkg::MUL_W - brc_pkg::COEF_W){1'b0}}, cfg.ohmic_resistance};
			end
			brc_pkg::OP_IK: begin
				mul_a = cur_ext;
				mul_b = {{(brc_pkg::MUL_W - brc_pkg::COEF_W){1'b0}}, cfg.soc_step_per_amp};
			end
			brc_pkg::OP_AV: begin
				mul_a = {{(brc_pkg::MUL_W - brc_pkg::DECAY_W){1'b0}}, cfg.rc_decay};
				mul_b = {{(brc_pkg::MUL_W - brc_pkg::VRC_W){vrc_q[brc_pkg::VRC_W-1]}}, vrc_q};
			end
			brc_pkg::OP_GI: begin
				mul_a = {{(brc_pkg::MUL_W - brc_pkg::COEF_W){1'b0}}, cfg.rc_gain};
				mul_b = cur_ext;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Arithmetic shifts of the registered product; each term fits its accumulator.
	assign sh30 = prod_s1 >>> 30;
	assign sh24 = prod_s1 >>> 24;
	assign sh16 = prod_s1 >>> 16;

	assign vrc_sh8   = vrc_q >>> 8;
	assign volt_init = {{(brc_pkg::VACC_W - brc_pkg::COEF_W){cfg.ocv_offset[brc_pkg::COEF_W-1]}},
		cfg.ocv_offset} - vrc_sh8[brc_pkg::VACC_W-1:0];

	always_comb begin
		if (volt_acc_q > 28'sd8388607) begin
			volt_sat = 24'sh7FFFFF;
		end else if (volt_acc_q < -28'sd8388608) begin
			volt_sat = 24'sh800000;
		end else begin
			volt_sat = volt_acc_q[brc_pkg::VOLT_W-1:0];
		end

		if (soc_next_q < 34'sd0) begin
			soc_clamped = '0;
		end else if (soc_next_q > 34'sd1073741824) begin
			soc_clamped = brc_pkg::SOC_ONE;
		end else begin
			soc_clamped = soc_next_q[brc_pkg::SOC_W-1:0];
		end

		if (vrc_next_q > 35'sd2147483647) begin
			vrc_sat = 32'sh7FFFFFFF;
		end else if (vrc_next_q < -35'sd2147483648) begin
			vrc_sat = 32'sh80000000;
		end else begin
			vrc_sat = vrc_next_q[brc_pkg::VRC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			soc_q  <= brc_pkg::SOC_ONE;
			vrc_q  <= '0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.commit) begin
				soc_q <= soc_clamped;
				vrc_q <= vrc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		op_s1   <= cmd.op;

		if (cmd.load) begin
			cur_q      <= cell_current;
			volt_acc_q <= volt_init;
			soc_next_q <= {{(brc_pkg::SACC_W - brc_pkg::SOC_W){1'b0}}, soc_q};
			vrc_next_q <= '0;
		end else if (vld_s1) begin
			unique case (op_s1)
				brc_pkg::OP_SS:   sq_q       <= sh30[brc_pkg::SOC_W-1:0];
				brc_pkg::OP_C1S:  volt_acc_q <= volt_acc_q + sh30[brc_pkg::VACC_W-1:0];
				brc_pkg::OP_C2SQ: volt_acc_q <= volt_acc_q + sh30[brc_pkg::VACC_W-1:0];
				brc_pkg::OP_IR0:  volt_acc_q <= volt_acc_q - sh24[brc_pkg::VACC_W-1:0];
				brc_pkg::OP_IK:   soc_next_q <= soc_next_q - sh16[brc_pkg::SACC_W-1:0];
				brc_pkg::OP_AV:   vrc_next_q <= vrc_next_q + sh24[brc_pkg::RACC_W-1:0];
				brc_pkg::OP_GI:   vrc_next_q <= vrc_next_q + sh16[brc_pkg::RACC_W-1:0];
				default: begin
				end
			endcase
		end

		// The reported charge is the level held before this step's update.
		if (cmd.commit) begin
			volt_out_q <= volt_sat;
			soc_out_q  <= soc_q;
		end
	end

	assign terminal_voltage = volt_out_q;
	assign state_of_charge  = soc_out_q;

endmodule

[rtl/battery_rc_model_step_unit.sv]
// Top level of the battery RC model step unit.
//
//   channel  | direction | payload                                   | handshake
//   step     | in        | cell_current                              | valid/ready
//   result   | out       | terminal_voltage, state_of_charge         | valid/ready
//   cfg      | in        | cfg_index, cfg_data                       | cfg_wr_en
//
// Each step issues seven products one per cycle through a single 33 x 33 multiplier,
// then drains the product register and commits the result.
// A finished result waits in its output register while the next step is accepted;
// if that register is still full when the next result is done, the unit holds.
// After reset the state of charge is full and the RC branch voltage is zero.
module battery_rc_model_step_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	brc_in_if.sink                            step,
	brc_out_if.source                         result,
	input  logic                              cfg_wr_en,
	input  logic [brc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [brc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	brc_pkg::cfg_t cfg;
	brc_pkg::cmd_t cmd;
	logic          in_ready;
	logic          out_valid;

	brc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	brc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	brc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.cell_current     (step.cell_current),
		.terminal_voltage (result.terminal_voltage),
		.state_of_charge  (result.state_of_charge)
	);

	assign step.ready   = in_ready;
	assign result.valid = out_valid;

endmodule

[rtl/brc_checker.sv]
// Port-level checker of the battery RC model step unit and its bind statement.
`include "battery_rc_model_step_unit_assert.svh"

module brc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [brc_pkg::VOLT_W-1:0] terminal_voltage,
	input logic [brc_pkg::SOC_W-1:0]         state_of_charge
);

	// A stalled result stays offered.
	`BRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result keeps its payload.
	`BRC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		($stable(terminal_voltage) && $stable(state_of_charge)))

	// The reported charge never exceeds full.
	`BRC_ASSERT_NOW(a_soc_range, clk, arst_n, out_valid, (state_of_charge <= brc_pkg::SOC_ONE))

	// No new transaction is taken while a step is still being computed.
	`BRC_ASSERT_NOW(a_busy, clk, arst_n, in_valid && in_ready, ##9 !in_ready)

endmodule

bind battery_rc_model_step_unit brc_checker u_brc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (step.valid),
	.in_ready         (step.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.terminal_voltage (result.terminal_voltage),
	.state_of_charge  (result.state_of_charge)
);
